>>> src/utf8_stream_validator_defines.svh
// Assertion macros for the UTF-8 stream validator.
// Used by files that check the validator's own logic; no other dependencies.
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// Check on every clock edge outside reset.
`define UTF8SV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define UTF8SV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/utf8sv_pkg.sv
// Shared types and constants of the UTF-8 stream validator.
// No dependencies.
package utf8sv_pkg;

    // Width of the byte counter and the offset registers.
    localparam int OFFSET_BITS = 32;
    // Width of the offset fields on the output word.
    localparam int OUT_BITS    = 32;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    // Byte classes and masks.
    localparam logic [7:0] MASK_TOP2   = 8'hc0;
    localparam logic [7:0] MASK_TOP3   = 8'he0;
    localparam logic [7:0] MASK_TOP4   = 8'hf0;
    localparam logic [7:0] MASK_TOP5   = 8'hf8;
    localparam logic [7:0] MASK_TOP7   = 8'hfe;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] CONT_BITS   = 8'h80;
    localparam logic [7:0] LEAD2_BITS  = 8'hc0;
    localparam logic [7:0] LEAD3_BITS  = 8'he0;
    localparam logic [7:0] LEAD4_BITS  = 8'hf0;
    localparam logic [7:0] LEAD4_MAX   = 8'hf4;

    // Lead bytes with a narrowed second-byte range, and EF for U+FFFE/U+FFFF.
    localparam logic [7:0] LEAD_E0     = 8'he0;
    localparam logic [7:0] LEAD_ED     = 8'hed;
    localparam logic [7:0] LEAD_EF     = 8'hef;
    localparam logic [7:0] LEAD_F0     = 8'hf0;
    localparam logic [7:0] LEAD_F4     = 8'hf4;
    localparam logic [7:0] SURR_BITS   = 8'ha0;
    localparam logic [7:0] F4_SEC_MAX  = 8'h8f;
    localparam logic [7:0] NONCH_SEC   = 8'hbf;
    localparam logic [7:0] NONCH_THIRD = 8'hbe;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_item;
    } t_in_word;

    typedef struct packed {
        logic                is_valid;
        logic [OUT_BITS-1:0] first_bad_offset;
        logic [OUT_BITS-1:0] string_length;
    } t_result;

    // Zero-extend or truncate a counter value to the output field width.
    function automatic logic [OUT_BITS-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+OUT_BITS-1:0] wide;
        wide = {{OUT_BITS{1'b0}}, v};
        return wide[OUT_BITS-1:0];
    endfunction

endpackage

>>> src/utf8sv_in_reg.sv
// Input register of the UTF-8 stream validator: holds one accepted word.
// Depends on utf8sv_pkg.
module utf8sv_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  utf8sv_pkg::t_in_word i_word,
    output logic                o_valid,
    output utf8sv_pkg::t_in_word o_word,
    input  logic                i_take
);

    logic                 r_valid;
    utf8sv_pkg::t_in_word r_word;

    // Refill in the same cycle the core consumes the held word.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

>>> src/utf8sv_core.sv
// Sequence tracker of the UTF-8 stream validator: per-string state and the
// one-byte update step. Depends on utf8sv_pkg.
module utf8sv_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  utf8sv_pkg::t_in_word i_word,
    input  logic                 i_out_free,
    output logic                 o_take,
    output logic                 o_res_valid,
    output utf8sv_pkg::t_result  o_res
);

    localparam int OB = utf8sv_pkg::OFFSET_BITS;

    logic [OB-1:0] r_byte_count, n_byte_count;
    logic [OB-1:0] r_seq_start,  n_seq_start;
    logic [1:0]    r_need,       n_need;
    logic [7:0]    r_lead,       n_lead;
    logic [7:0]    r_second,     n_second;
    logic [1:0]    r_idx,        n_idx;
    logic          r_err,        n_err;
    logic [OB-1:0] r_err_off,    n_err_off;

    logic [7:0]    b;
    logic          bad;
    logic          fin_err;
    logic [OB-1:0] fin_off;

    // A last word waits until the result register has room.
    assign o_take      = i_valid && (!i_word.last_item || i_out_free);
    assign o_res_valid = o_take && i_word.last_item;
    assign b           = i_word.data_byte;

    always_comb begin
        n_byte_count = r_byte_count;
        n_seq_start  = r_seq_start;
        n_need       = r_need;
        n_lead       = r_lead;
        n_second     = r_second;
        n_idx        = r_idx;
        n_err        = r_err;
        n_err_off    = r_err_off;
        bad          = 1'b0;
        fin_err      = 1'b0;
        fin_off      = '0;
        o_res        = '0;

        if (o_take && i_word.has_byte) begin
            if (r_byte_count != utf8sv_pkg::COUNT_MAX) begin
                n_byte_count = r_byte_count + 1'b1;
            end
            if (!r_err) begin
                if (r_need == 2'd0) begin
                    // Expecting a lead byte.
                    if (b < utf8sv_pkg::ASCII_LIMIT) begin
                        n_need = 2'd0;
                    end else if ((b & utf8sv_pkg::MASK_TOP3) == utf8sv_pkg::LEAD2_BITS) begin
                        if ((b & utf8sv_pkg::MASK_TOP7) == utf8sv_pkg::LEAD2_BITS) begin
                            bad = 1'b1;    // overlong two-byte lead
                        end else begin
                            n_seq_start = r_byte_count;
                            n_lead      = b;
                            n_idx       = 2'd1;
                            n_need      = 2'd1;
                        end
                    end else if ((b & utf8sv_pkg::MASK_TOP4) == utf8sv_pkg::LEAD3_BITS) begin
                        n_seq_start = r_byte_count;
                        n_lead      = b;
                        n_idx       = 2'd1;
                        n_need      = 2'd2;
                    end else if ((b & utf8sv_pkg::MASK_TOP5) == utf8sv_pkg::LEAD4_BITS) begin
                        if (b > utf8sv_pkg::LEAD4_MAX) begin
                            bad = 1'b1;    // beyond U+10FFFF
                        end else begin
                            n_seq_start = r_byte_count;
                            n_lead      = b;
                            n_idx       = 2'd1;
                            n_need      = 2'd3;
                        end
                    end else begin
                        bad = 1'b1;        // stray continuation or F8..FF
                    end
                    if (bad) begin
                        n_err     = 1'b1;
                        n_err_off = r_byte_count;
                        n_need    = 2'd0;
                        n_idx     = 2'd0;
                    end
                end else begin
                    // Expecting a continuation byte.
                    bad = (b & utf8sv_pkg::MASK_TOP2) != utf8sv_pkg::CONT_BITS;
                    if (r_idx == 2'd1) begin
                        n_second = b;
                        if (r_lead == utf8sv_pkg::LEAD_E0
                            && (b & utf8sv_pkg::MASK_TOP3) == utf8sv_pkg::CONT_BITS) begin
                            bad = 1'b1;
                        end
                        if (r_lead == utf8sv_pkg::LEAD_ED
                            && (b & utf8sv_pkg::MASK_TOP3) == utf8sv_pkg::SURR_BITS) begin
                            bad = 1'b1;
                        end
                        if (r_lead == utf8sv_pkg::LEAD_F0
                            && (b & utf8sv_pkg::MASK_TOP4) == utf8sv_pkg::CONT_BITS) begin
                            bad = 1'b1;
                        end
                        if (r_lead == utf8sv_pkg::LEAD_F4 && b > utf8sv_pkg::F4_SEC_MAX) begin
                            bad = 1'b1;
                        end
                    end else if (r_idx == 2'd2) begin
                        // U+FFFE and U+FFFF
                        if (r_lead == utf8sv_pkg::LEAD_EF && r_second == utf8sv_pkg::NONCH_SEC
                            && (b & utf8sv_pkg::MASK_TOP7) == utf8sv_pkg::NONCH_THIRD) begin
                            bad = 1'b1;
                        end
                    end
                    if (bad) begin
                        n_err     = 1'b1;
                        n_err_off = r_seq_start;
                        n_need    = 2'd0;
                        n_idx     = 2'd0;
                    end else begin
                        n_need = r_need - 2'd1;
                        n_idx  = (r_need == 2'd1) ? 2'd0 : r_idx + 2'd1;
                    end
                end
            end
        end

        if (o_res_valid) begin
            // Truncated sequence counts as an error at its lead byte.
            fin_err = n_err || (n_need != 2'd0);
            if (n_err) begin
                fin_off = n_err_off;
            end else if (n_need != 2'd0) begin
                fin_off = n_seq_start;
            end else begin
                fin_off = n_byte_count;
            end
            o_res.is_valid         = !fin_err;
            o_res.first_bad_offset = utf8sv_pkg::to_out(fin_off);
            o_res.string_length    = utf8sv_pkg::to_out(n_byte_count);

            n_byte_count = '0;
            n_seq_start  = '0;
            n_need       = 2'd0;
            n_lead       = '0;
            n_second     = '0;
            n_idx        = 2'd0;
            n_err        = 1'b0;
            n_err_off    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_seq_start  <= '0;
            r_need       <= 2'd0;
            r_lead       <= '0;
            r_second     <= '0;
            r_idx        <= 2'd0;
            r_err        <= 1'b0;
            r_err_off    <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            r_seq_start  <= n_seq_start;
            r_need       <= n_need;
            r_lead       <= n_lead;
            r_second     <= n_second;
            r_idx        <= n_idx;
            r_err        <= n_err;
            r_err_off    <= n_err_off;
        end
    end

endmodule

>>> src/utf8sv_out_reg.sv
// Result register of the UTF-8 stream validator: holds one result word
// until the receiver takes it. Depends on utf8sv_pkg.
module utf8sv_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  utf8sv_pkg::t_result i_res,
    output logic                o_free,
    output logic                o_valid,
    output utf8sv_pkg::t_result o_res,
    input  logic                i_ready
);

    logic                r_valid;
    utf8sv_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

>>> src/utf8_stream_validator.sv
// UTF-8 stream validator, top level.
// Use: a string enters one byte per word on the slave stream; tuser marks a
// word that carries a byte, tlast ends the string. A word with tuser low and
// tlast high ends a string without adding a byte (empty strings).
// On the word that ends a string one result word leaves on the master stream:
// tuser = is_valid, tdata = first bad offset (low 32) and length (high 32).
// Bad strings report the offset of the lead byte of the first bad sequence,
// stray continuation bytes and F8..FF their own offset. Counts saturate.
// Throughput: one word per cycle while no last word waits on a full result
// register, set by the single update step between the input register and the result register.
// A result is written into the result register when the core takes its last word.
// Stall: while an unread result sits in the result register, bytes that end
// no string still flow; the next last word waits in the input register, and
// the slave tready drops once that register is full.
// Reset (synchronous, active low) empties both registers and clears the
// per-string state; the next byte starts a new string at offset 0.
// Depends on utf8sv_pkg, utf8sv_in_reg, utf8sv_core, utf8sv_out_reg and the
// assertion macro header.
`include "utf8_stream_validator_defines.svh"

module utf8_stream_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] data_byte
    input  logic        i_s_tuser,     // [0] has_byte
    input  logic        i_s_tlast,     // last_item
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,     // [31:0] first_bad_offset, [63:32] string_length
    output logic        o_m_tuser      // [0] is_valid
);

    utf8sv_pkg::t_in_word w_in_word;
    utf8sv_pkg::t_in_word w_word;
    utf8sv_pkg::t_result  w_res;
    utf8sv_pkg::t_result  w_out_res;
    logic                 w_word_valid;
    logic                 w_take;
    logic                 w_res_valid;
    logic                 w_out_free;

    assign w_in_word.data_byte = i_s_tdata;
    assign w_in_word.has_byte  = i_s_tuser;
    assign w_in_word.last_item = i_s_tlast;

    utf8sv_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_word  (w_in_word),
        .o_valid (w_word_valid),
        .o_word  (w_word),
        .i_take  (w_take)
    );

    utf8sv_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_word_valid),
        .i_word      (w_word),
        .i_out_free  (w_out_free),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    utf8sv_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_free      (w_out_free),
        .o_valid     (o_m_tvalid),
        .o_res       (w_out_res),
        .i_ready     (i_m_tready)
    );

    assign o_m_tuser = w_out_res.is_valid;
    assign o_m_tdata = {w_out_res.string_length, w_out_res.first_bad_offset};

    // A string end taken by the core shows up as a result on the next cycle.
    `UTF8SV_ASSERT(a_end_gives_result, (w_take && w_word.last_item) |=> o_m_tvalid, "end lost")
    // A valid string reports its length as the offset.
    `UTF8SV_ASSERT(a_valid_offset, (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[31:0] == o_m_tdata[63:32]), "bad offset")
    // No result survives reset.
    `UTF8SV_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule
